// ===== rtl/core/vdh_pkg.sv =====
// ---------------------------------------------------------------------------
// vdh_pkg
// Shared sizes, payload types and controller/datapath interface types for
// the vertex deduplication hash table.
// ---------------------------------------------------------------------------
package vdh_pkg;

    localparam int MAX_VERTICES  = 4096;
    localparam int MAX_BUCKETS   = 1024;
    localparam int NODE_DEPTH    = MAX_BUCKETS + MAX_VERTICES;

    localparam int KEY_W         = 32;
    localparam int VI_W          = $clog2(MAX_VERTICES);
    localparam int VC_W          = VI_W + 1;
    localparam int NODE_AW       = $clog2(NODE_DEPTH);
    localparam int NB_W          = 11;
    localparam int CLR_W         = $clog2(MAX_BUCKETS);

    // Remainder unit: 32 dividend bits in 8 passes
    localparam int MOD_STEPS     = 8;
    localparam int BITS_PER_STEP = KEY_W / MOD_STEPS;
    localparam int ITER_W        = $clog2(MOD_STEPS);

    // Register port
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_BIT   = 2;
    localparam logic REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0] key_x;
        logic [KEY_W-1:0] key_y;
        logic [KEY_W-1:0] key_z;
    } t_in_item;

    typedef struct packed {
        logic [VI_W-1:0] vertex_index;
        logic            was_new;
        logic            table_full;
    } t_out_item;

    typedef struct packed {
        logic [NODE_AW-1:0] next;
        logic [VI_W-1:0]    index;
    } t_node;

    typedef enum logic [1:0] {
        RES_HIT_J  = 2'd0,
        RES_HIT_VI = 2'd1,
        RES_NEW    = 2'd2,
        RES_FULL   = 2'd3
    } t_res_sel;

    typedef struct packed {
        logic     load_key;
        logic     mod_step;
        logic     clr_wr;
        logic     vrd_node;
        logic     lin_next;
        logic     latch_node;
        logic     follow;
        logic     ins_vtx;
        logic     ins_node_s;
        logic     ins_node_tail;
        logic     bump;
        logic     res_ld;
        t_res_sel res_sel;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic clr_last;
        logic hash_mode;
        logic lin_end;
        logic nx_zero;
        logic key_match;
        logic vi_ok;
        logic walk_stop;
        logic full;
    } t_sts;

    function automatic logic [NB_W-1:0] eff_buckets(input logic [NB_W-1:0] v);
        return (v > NB_W'(MAX_BUCKETS)) ? NB_W'(MAX_BUCKETS) : v;
    endfunction

endpackage

// ===== rtl/core/vdh_ram.sv =====
// ---------------------------------------------------------------------------
// vdh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/vdh_ctrl.sv =====
// ---------------------------------------------------------------------------
// vdh_ctrl
// Sequencer for clearing, remainder passes, searches and inserts.
// ---------------------------------------------------------------------------
module vdh_ctrl
    import vdh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_MOD   = 12'b0000_0000_0100,
        S_NRD   = 12'b0000_0000_1000,
        S_NCHK  = 12'b0000_0001_0000,
        S_VCMP  = 12'b0000_0010_0000,
        S_LRD   = 12'b0000_0100_0000,
        S_LCMP  = 12'b0000_1000_0000,
        S_DEC   = 12'b0001_0000_0000,
        S_INS1  = 12'b0010_0000_0000,
        S_INS2  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    t_cmd              cmd;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_key = 1'b1;
                    n_iter       = '0;
                    n_state      = i_sts.hash_mode ? S_MOD : S_LRD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                n_iter       = r_iter + 1'b1;
                if (r_iter == ITER_W'(MOD_STEPS - 1)) begin
                    n_state = S_NRD;
                end
            end
            S_NRD: begin
                n_state = S_NCHK;
            end
            S_NCHK: begin
                cmd.latch_node = 1'b1;
                cmd.vrd_node   = 1'b1;
                n_state        = i_sts.nx_zero ? S_DEC : S_VCMP;
            end
            S_VCMP: begin
                if (i_sts.key_match && i_sts.vi_ok) begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_HIT_VI;
                    n_state     = S_OUT;
                end else if (i_sts.walk_stop) begin
                    n_state = S_DEC;
                end else begin
                    cmd.follow = 1'b1;
                    n_state    = S_NRD;
                end
            end
            S_LRD: begin
                n_state = i_sts.lin_end ? S_DEC : S_LCMP;
            end
            S_LCMP: begin
                if (i_sts.key_match) begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_HIT_J;
                    n_state     = S_OUT;
                end else begin
                    cmd.lin_next = 1'b1;
                    n_state      = S_LRD;
                end
            end
            S_DEC: begin
                if (i_sts.full) begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_FULL;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_INS1;
                end
            end
            S_INS1: begin
                cmd.ins_vtx = 1'b1;
                if (i_sts.hash_mode) begin
                    cmd.ins_node_s = 1'b1;
                    n_state        = S_INS2;
                end else begin
                    cmd.bump    = 1'b1;
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_NEW;
                    n_state     = S_OUT;
                end
            end
            S_INS2: begin
                cmd.ins_node_tail = 1'b1;
                cmd.bump          = 1'b1;
                cmd.res_ld        = 1'b1;
                cmd.res_sel       = RES_NEW;
                n_state           = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // restart the sweep on every bucket_count write
        if (i_sts.cfg_wr) begin
            n_state = S_CLEAR;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.out_ld) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== rtl/core/vdh_datapath.sv =====
// ---------------------------------------------------------------------------
// vdh_datapath
// Key, counters, remainder unit, store addressing, result and register port.
// ---------------------------------------------------------------------------
module vdh_datapath
    import vdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  t_in_item          i_in_data,
    output t_out_item         o_out_data,
    // vertex store
    output logic              o_vtx_we,
    output logic [VI_W-1:0]   o_vtx_waddr,
    output t_in_item          o_vtx_wdata,
    output logic [VI_W-1:0]   o_vtx_raddr,
    input  t_in_item          i_vtx_rdata,
    // node store
    output logic              o_node_we,
    output logic [NODE_AW-1:0] o_node_waddr,
    output t_node             o_node_wdata,
    output logic [NODE_AW-1:0] o_node_raddr,
    input  t_node             i_node_rdata,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata
);

    t_in_item           r_key;
    logic [KEY_W-1:0]   r_div;
    logic [NB_W-1:0]    r_rem;
    logic [NODE_AW-1:0] r_s;
    logic [NODE_AW-1:0] r_nx;
    logic [VI_W-1:0]    r_vi;
    logic [VC_W-1:0]    r_j;
    logic [NODE_AW-1:0] r_steps;
    logic [VC_W-1:0]    r_vcount;
    logic [NODE_AW-1:0] r_ncount;
    logic [NB_W-1:0]    r_bcount;
    logic [NB_W-1:0]    r_nb;
    logic [CLR_W-1:0]   r_clr;
    t_out_item          r_res;
    t_out_item          r_out;

    logic               cfg_wr;
    logic [NB_W-1:0]    cfg_nb;
    logic [NB_W-1:0]    mod_rem;
    logic [KEY_W-1:0]   mod_div;
    logic [NB_W:0]      mod_t;
    logic               hash_mode;

    assign cfg_wr    = psel && penable && pwrite && (paddr[REG_IDX_BIT] == REG_BUCKET_COUNT);
    assign cfg_nb    = eff_buckets(pwdata[NB_W-1:0]);
    assign hash_mode = (r_nb != '0);
    assign prdata    = (paddr[REG_IDX_BIT] == REG_BUCKET_COUNT) ?
                       {{(APB_DW-NB_W){1'b0}}, r_bcount} : '0;

    // four restoring steps per pass; remainder stays below r_nb
    always_comb begin
        mod_rem = r_rem;
        mod_div = r_div;
        mod_t   = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            mod_t   = {mod_rem, mod_div[KEY_W-1]};
            mod_div = {mod_div[KEY_W-2:0], 1'b0};
            if (mod_t >= {1'b0, r_nb}) begin
                mod_t = mod_t - {1'b0, r_nb};
            end
            mod_rem = mod_t[NB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key   <= i_in_data;
            r_div   <= i_in_data.key_x + i_in_data.key_y + i_in_data.key_z;
            r_rem   <= '0;
            r_j     <= '0;
            r_steps <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= mod_rem;
            r_div <= mod_div;
            r_s   <= {{(NODE_AW-NB_W){1'b0}}, mod_rem};
        end
        if (i_cmd.latch_node) begin
            r_nx <= i_node_rdata.next;
            r_vi <= i_node_rdata.index;
        end
        if (i_cmd.follow) begin
            r_s     <= r_nx;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.lin_next) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                RES_HIT_J:  r_res <= '{vertex_index: r_j[VI_W-1:0], was_new: 1'b0,
                                       table_full: 1'b0};
                RES_HIT_VI: r_res <= '{vertex_index: r_vi, was_new: 1'b0,
                                       table_full: 1'b0};
                RES_NEW:    r_res <= '{vertex_index: r_vcount[VI_W-1:0], was_new: 1'b1,
                                       table_full: 1'b0};
                default:    r_res <= '{vertex_index: '0, was_new: 1'b0,
                                       table_full: 1'b1};
            endcase
        end
        if (i_cmd.out_ld) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= '0;
            r_nb     <= '0;
            r_vcount <= '0;
            r_ncount <= '0;
            r_clr    <= '0;
        end else if (cfg_wr) begin
            r_bcount <= pwdata[NB_W-1:0];
            r_nb     <= cfg_nb;
            r_vcount <= '0;
            r_ncount <= {{(NODE_AW-NB_W){1'b0}}, cfg_nb};
            r_clr    <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.bump) begin
                r_vcount <= r_vcount + 1'b1;
                if (hash_mode) begin
                    r_ncount <= r_ncount + 1'b1;
                end
            end
        end
    end

    // store addressing
    assign o_vtx_we    = i_cmd.ins_vtx;
    assign o_vtx_waddr = r_vcount[VI_W-1:0];
    assign o_vtx_wdata = r_key;
    assign o_vtx_raddr = i_cmd.vrd_node ? i_node_rdata.index : r_j[VI_W-1:0];

    always_comb begin
        o_node_we    = i_cmd.clr_wr || i_cmd.ins_node_s || i_cmd.ins_node_tail;
        o_node_waddr = {{(NODE_AW-CLR_W){1'b0}}, r_clr};
        o_node_wdata = '0;
        if (i_cmd.ins_node_s) begin
            o_node_waddr = r_s;
            o_node_wdata = '{next: r_ncount, index: r_vcount[VI_W-1:0]};
        end else if (i_cmd.ins_node_tail) begin
            o_node_waddr = r_ncount;
        end
    end
    assign o_node_raddr = r_s;

    always_comb begin
        o_sts.cfg_wr    = cfg_wr;
        o_sts.clr_last  = (r_clr == CLR_W'(MAX_BUCKETS - 1));
        o_sts.hash_mode = hash_mode;
        o_sts.lin_end   = (r_j >= r_vcount);
        o_sts.nx_zero   = (i_node_rdata.next == '0);
        o_sts.key_match = (i_vtx_rdata == r_key);
        o_sts.vi_ok     = ({1'b0, r_vi} < r_vcount);
        o_sts.walk_stop = (r_nx >= NODE_AW'(NODE_DEPTH)) || (r_steps >= r_ncount);
        o_sts.full      = (r_vcount >= VC_W'(MAX_VERTICES)) ||
                          (hash_mode && ((r_ncount >= NODE_AW'(NODE_DEPTH)) || (r_nx != '0)));
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/core/vertex_dedup_hash_table.sv =====
// ---------------------------------------------------------------------------
// vertex_dedup_hash_table
// Vertex key deduplication over a chained hash table or a linear search.
// ---------------------------------------------------------------------------
// Hashed mode: the radix-16 remainder unit picks the bucket, then the chain
//   from that bucket is walked link by link.
// Linear mode (bucket_count zero): each stored key takes one vertex store
//   read and compare.
// One beat is in flight at a time; a finished result waits in the output
//   register while the next beat is accepted.
// Reset (i_rst_n low, synchronous) and every bucket_count write start a
//   sweep clearing the 1024 bucket nodes; no beat is accepted meanwhile.
// ---------------------------------------------------------------------------
module vertex_dedup_hash_table
    import vdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd               cmd;
    t_sts               sts;

    logic               vtx_we;
    logic [VI_W-1:0]    vtx_waddr;
    logic [VI_W-1:0]    vtx_raddr;
    t_in_item           vtx_wdata;
    t_in_item           vtx_rdata;

    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [NODE_AW-1:0] node_raddr;
    t_node              node_wdata;
    t_node              node_rdata;

    // zero wait states on the register port
    assign pready = 1'b1;

    // Sequencer: clear sweep, remainder passes, chain walk or linear search, insert
    vdh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: key, counters, remainder unit, store addressing, register
    vdh_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_data    (i_in_data),
        .o_out_data   (o_out_data),
        .o_vtx_we     (vtx_we),
        .o_vtx_waddr  (vtx_waddr),
        .o_vtx_wdata  (vtx_wdata),
        .o_vtx_raddr  (vtx_raddr),
        .i_vtx_rdata  (vtx_rdata),
        .o_node_we    (node_we),
        .o_node_waddr (node_waddr),
        .o_node_wdata (node_wdata),
        .o_node_raddr (node_raddr),
        .i_node_rdata (node_rdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata)
    );

    // Vertex store: one 96-bit key per entry, only entries below the count are used
    vdh_ram #(
        .WIDTH ($bits(t_in_item)),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (vtx_waddr),
        .i_wdata (vtx_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    // Node store: bucket heads first, then appended chain nodes
    vdh_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

endmodule

// ===== rtl/core/vdh_checker.sv =====
// ---------------------------------------------------------------------------
// vdh_checker
// Port-level checks on the deduplication table, bound to the top level.
// ---------------------------------------------------------------------------
module vdh_checker
    import vdh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // one beat at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.was_new && o_out_data.table_full))
        else $error("result both new and full");

    a_full_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full) |-> (o_out_data.vertex_index == '0))
        else $error("full result with non-zero index");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

endmodule

bind vertex_dedup_hash_table vdh_checker u_vdh_checker (.*);
